// ===== hdl/assert_macros.svh =====
// Assertion shorthands for the 3x3 median filter.
// Needs a signal named clock and a signal named reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Whenever the first expression holds, the second holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mf3_pkg.sv =====
// Shared types and constants of the 3x3 median filter.
// No dependencies; used by mf3_median and median_filter_3x3_rgb.
package mf3_pkg;

   // Frame geometry limits and derived index widths.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // Configuration port.
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // Item kinds on the input channel.
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef logic [7:0] chan_type;

   // Channel 0 (blue) sits in the low byte.
   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

   typedef struct packed {
      logic     mode;
      chan_type blue_in;
      chan_type green_in;
      chan_type red_in;
   } req_type;

   typedef struct packed {
      chan_type blue_out;
      chan_type green_out;
      chan_type red_out;
      logic     frame_done;
   } rsp_type;

   // Load strobes for the two stages of the median unit.
   typedef struct packed {
      logic load_sort;
      logic load_median;
   } med_en_type;

endpackage

// ===== hdl/mf3_median.sv =====
// Two-stage median of nine 8-bit values for one color channel.
// Depends on mf3_pkg for chan_type and med_en_type.
module mf3_median import mf3_pkg::*; (
   input  logic            clock,
   input  med_en_type      en,
   input  chan_type [8:0]  taps,
   output chan_type        median
);

   chan_type [2:0] lo_ff;
   chan_type [2:0] mid_ff;
   chan_type [2:0] hi_ff;
   chan_type       median_ff;

   function automatic chan_type min3(input chan_type a, input chan_type b, input chan_type c);
      chan_type m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic chan_type max3(input chan_type a, input chan_type b, input chan_type c);
      chan_type m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic chan_type med3(input chan_type a, input chan_type b, input chan_type c);
      chan_type m;
      if (a > b) begin
         m = (b > c) ? b : ((a > c) ? c : a);
      end else begin
         m = (a > c) ? a : ((b > c) ? c : b);
      end
      return m;
   endfunction

   // First stage: sort each column of three taps.
   always_ff @(posedge clock) begin
      if (en.load_sort) begin
         for (int t = 0; t < 3; t++) begin
            lo_ff[t]  <= min3(taps[3*t], taps[3*t+1], taps[3*t+2]);
            mid_ff[t] <= med3(taps[3*t], taps[3*t+1], taps[3*t+2]);
            hi_ff[t]  <= max3(taps[3*t], taps[3*t+1], taps[3*t+2]);
         end
      end
   end

   // Second stage: the median of nine is the median of the largest minimum,
   // the middle median and the smallest maximum.
   always_ff @(posedge clock) begin
      if (en.load_median) begin
         median_ff <= med3(max3(lo_ff[0], lo_ff[1], lo_ff[2]),
                           med3(mid_ff[0], mid_ff[1], mid_ff[2]),
                           min3(hi_ff[0], hi_ff[1], hi_ff[2]));
      end
   end

   assign median = median_ff;

endmodule

// ===== hdl/median_filter_3x3_rgb.sv =====
// Streaming 3x3 per-channel median filter for 8-bit BGR pixels in raster order.
// Depends on mf3_pkg, mf3_median and assert_macros.svh.
//
// The block takes one item per clock when not stalled and gives at most one result per
// item. Pixel items enter in raster order; each result is the per-channel median of the
// 3x3 neighborhood with edge pixels replicated at the borders. A frame of W x H pixels
// (W and H latched from frame_width and frame_height at the first pixel of the frame,
// clamped to 1..1024 and 1..4096) yields its first result on pixel W+2 (fewer
// for one-row or one-column frames) and one result per pixel after that; the remaining
// results, W+1 at most, are released by flush items sent after the last pixel, one per
// flush, the final one carrying frame_done. A result goes from stage one through the
// sort stage into the output register. The one-per-clock rate is set by the two
// line-store memories, each read once and written once per cycle; a pixel whose column
// is being written takes its data from a forwarding register instead of the memory.
// A pixel sent while results of a finished frame are still pending drops those results
// and opens a new frame. Line stores need no clearing and the block is ready from reset.
`include "assert_macros.svh"

module median_filter_3x3_rgb import mf3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   // Configuration registers.
   logic [FW_W-1:0]  frame_width_ff;
   logic [FH_W-1:0]  frame_height_ff;

   // Frame position and drain control.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] last_col_ff, last_col_in;
   logic [ROW_W-1:0] last_row_ff, last_row_in;
   logic             drain_ff, drain_in;
   logic             wrap_ff, wrap_in;

   // Item decode at acceptance.
   logic             accept;
   logic             is_pixel;
   logic             frame_start;
   logic [COL_W-1:0] p_col;
   logic [ROW_W-1:0] p_row;
   logic             one_col;
   logic             one_row;
   logic             act;
   logic             emit;
   logic             done;
   pixel_type        pixel_in;

   // Line stores and their read data.
   pixel_type        upper_mem [MAX_WIDTH];
   pixel_type        middle_mem [MAX_WIDTH];
   pixel_type        upper_rd_ff;
   pixel_type        middle_rd_ff;
   logic             mem_wr;

   // Stage one: the item whose line-store data has just been read.
   logic             s1_valid_ff;
   logic             s1_is_pixel_ff;
   logic             s1_act_ff;
   logic             s1_emit_ff;
   logic             s1_done_ff;
   logic             s1_one_col_ff;
   logic             s1_one_row_ff;
   logic             s1_col0_ff;
   logic             s1_col1_ff;
   logic             s1_top_mid_ff;
   logic [COL_W-1:0] s1_addr_ff;
   pixel_type        s1_pixel_ff;
   logic             fwd_ff;
   pixel_type        fwd_upper_ff;
   pixel_type        fwd_middle_ff;
   pixel_type        eff_upper;
   pixel_type        eff_middle;
   column_type       new_col;
   column_type       win_left_ff;
   column_type       win_center_ff;
   column_type       win_right_ff;
   column_type       out_left;
   column_type       out_center;
   column_type       out_right;
   pixel_type        taps [9];
   chan_type [8:0]   blue_taps;
   chan_type [8:0]   green_taps;
   chan_type [8:0]   red_taps;

   // Median stages and handshake.
   logic             s2_valid_ff;
   logic             s2_done_ff;
   logic             s3_valid_ff;
   logic             s3_done_ff;
   logic             s1_move;
   logic             s2_free;
   logic             s3_free;
   med_en_type       med_en;
   chan_type         blue_med;
   chan_type         green_med;
   chan_type         red_med;

   function automatic logic [COL_W-1:0] last_col_of(input logic [FW_W-1:0] w);
      logic [COL_W-1:0] r;
      if (w == '0) begin
         r = '0;
      end else if (int'(w) > MAX_WIDTH) begin
         r = COL_W'(MAX_WIDTH - 1);
      end else begin
         r = COL_W'(int'(w) - 1);
      end
      return r;
   endfunction

   function automatic logic [ROW_W-1:0] last_row_of(input logic [FH_W-1:0] h);
      logic [ROW_W-1:0] r;
      if (h == '0) begin
         r = '0;
      end else if (int'(h) > MAX_HEIGHT) begin
         r = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         r = ROW_W'(int'(h) - 1);
      end
      return r;
   endfunction

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wr_data[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the pipeline compacts around bubbles, so an item is taken
   // while a finished result still waits in the output register.
   assign s3_free   = !s3_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_move   = s1_valid_ff && (!s1_emit_ff || s2_free);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   // Item decode. A pixel during the drain starts a new frame at the origin.
   assign is_pixel    = (req_data.mode == MODE_PIXEL);
   assign frame_start = is_pixel && (drain_ff || (row_ff == '0 && col_ff == '0));
   assign p_col       = (is_pixel && drain_ff) ? '0 : col_ff;
   assign p_row       = (is_pixel && drain_ff) ? '0 : row_ff;
   assign last_col_in = frame_start ? last_col_of(frame_width_ff) : last_col_ff;
   assign last_row_in = frame_start ? last_row_of(frame_height_ff) : last_row_ff;
   assign one_col     = (last_col_in == '0);
   assign one_row     = (last_row_in == '0);
   assign pixel_in    = {req_data.red_in, req_data.green_in, req_data.blue_in};

   // Whether this item releases a result, and where the frame goes next.
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      wrap_in  = wrap_ff;
      act      = 1'b0;
      emit     = 1'b0;
      done     = 1'b0;
      if (is_pixel) begin
         act      = 1'b1;
         wrap_in  = 1'b0;
         drain_in = 1'b0;
         if (one_row && one_col) begin
            emit = 1'b1;
            done = 1'b1;
         end else if (one_row) begin
            emit = (p_col != '0);
         end else if (one_col) begin
            emit = (p_row != '0);
         end else begin
            emit = (p_row > ROW_W'(1)) || (p_row == ROW_W'(1) && p_col != '0);
         end
         if (p_col == last_col_in) begin
            col_in = '0;
            if (p_row == last_row_in) begin
               row_in   = '0;
               drain_in = !(one_row && one_col);
            end else begin
               row_in = p_row + ROW_W'(1);
            end
         end else begin
            col_in = p_col + COL_W'(1);
            row_in = p_row;
         end
      end else if (drain_ff) begin
         // Flush items walk virtual columns below the last row.
         act  = 1'b1;
         emit = 1'b1;
         if (one_row || one_col || (wrap_ff && col_ff == '0)) begin
            done     = 1'b1;
            drain_in = 1'b0;
            wrap_in  = 1'b0;
            col_in   = '0;
            row_in   = '0;
         end else if (col_ff == last_col_in) begin
            col_in  = '0;
            wrap_in = 1'b1;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         drain_ff    <= 1'b0;
         wrap_ff     <= 1'b0;
         last_col_ff <= last_col_of(FRAME_WIDTH_RESET);
         last_row_ff <= last_row_of(FRAME_HEIGHT_RESET);
      end else if (accept) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         drain_ff    <= drain_in;
         wrap_ff     <= wrap_in;
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
      end
   end

   // Line stores: read at acceptance, written back from stage one.
   // The middle row moves up and the new pixel becomes the middle row.
   assign mem_wr = s1_move && s1_is_pixel_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         upper_rd_ff  <= upper_mem[p_col];
         middle_rd_ff <= middle_mem[p_col];
      end
      if (mem_wr) begin
         upper_mem[s1_addr_ff]  <= eff_middle;
         middle_mem[s1_addr_ff] <= s1_pixel_ff;
      end
   end

   // Stage one registers, with forwarding when the column written this
   // cycle is the one being read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
         fwd_ff      <= s1_valid_ff && s1_is_pixel_ff && (s1_addr_ff == p_col);
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_is_pixel_ff <= is_pixel;
         s1_act_ff      <= act;
         s1_emit_ff     <= emit;
         s1_done_ff     <= done;
         s1_one_col_ff  <= one_col;
         s1_one_row_ff  <= one_row;
         s1_col0_ff     <= (p_col == '0);
         s1_col1_ff     <= (p_col == COL_W'(1));
         s1_top_mid_ff  <= (p_row == ROW_W'(1));
         s1_addr_ff     <= p_col;
         s1_pixel_ff    <= pixel_in;
         fwd_upper_ff   <= eff_middle;
         fwd_middle_ff  <= s1_pixel_ff;
      end
   end

   assign eff_upper  = fwd_ff ? fwd_upper_ff : upper_rd_ff;
   assign eff_middle = fwd_ff ? fwd_middle_ff : middle_rd_ff;

   // New window column, with rows clamped at the top and bottom edges.
   always_comb begin
      if (s1_is_pixel_ff) begin
         if (s1_one_row_ff) begin
            new_col.top = s1_pixel_ff;
            new_col.mid = s1_pixel_ff;
         end else begin
            new_col.top = s1_top_mid_ff ? eff_middle : eff_upper;
            new_col.mid = eff_middle;
         end
         new_col.bot = s1_one_row_ff ? s1_pixel_ff : s1_pixel_ff;
      end else begin
         new_col.top = eff_upper;
         new_col.mid = eff_middle;
         new_col.bot = eff_middle;
      end
   end

   // Window shift register, one column per effective item.
   always_ff @(posedge clock) begin
      if (s1_move && s1_act_ff) begin
         win_left_ff   <= win_center_ff;
         win_center_ff <= win_right_ff;
         win_right_ff  <= new_col;
      end
   end

   // Neighborhood of the released result. At a row start the result is the
   // last column of the previous row, taken before the shift with the right
   // column replicated; in the first column the left column is replicated.
   always_comb begin
      if (s1_one_col_ff) begin
         out_left   = new_col;
         out_center = new_col;
         out_right  = new_col;
      end else if (s1_col0_ff) begin
         out_left   = win_center_ff;
         out_center = win_right_ff;
         out_right  = win_right_ff;
      end else begin
         out_left   = s1_col1_ff ? win_right_ff : win_center_ff;
         out_center = win_right_ff;
         out_right  = new_col;
      end
   end

   always_comb begin
      taps[0] = out_left.top;
      taps[1] = out_left.mid;
      taps[2] = out_left.bot;
      taps[3] = out_center.top;
      taps[4] = out_center.mid;
      taps[5] = out_center.bot;
      taps[6] = out_right.top;
      taps[7] = out_right.mid;
      taps[8] = out_right.bot;
      for (int i = 0; i < 9; i++) begin
         blue_taps[i]  = taps[i].blue;
         green_taps[i] = taps[i].green;
         red_taps[i]   = taps[i].red;
      end
   end

   // Median stages: only items that release a result enter them.
   assign med_en.load_sort   = s1_move && s1_emit_ff;
   assign med_en.load_median = s2_valid_ff && s3_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (med_en.load_sort) begin
            s2_valid_ff <= 1'b1;
         end else if (med_en.load_median) begin
            s2_valid_ff <= 1'b0;
         end
         if (med_en.load_median) begin
            s3_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            s3_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (med_en.load_sort) begin
         s2_done_ff <= s1_done_ff;
      end
      if (med_en.load_median) begin
         s3_done_ff <= s2_done_ff;
      end
   end

   mf3_median u_med_blue (
      .clock  (clock),
      .en     (med_en),
      .taps   (blue_taps),
      .median (blue_med)
   );

   mf3_median u_med_green (
      .clock  (clock),
      .en     (med_en),
      .taps   (green_taps),
      .median (green_med)
   );

   mf3_median u_med_red (
      .clock  (clock),
      .en     (med_en),
      .taps   (red_taps),
      .median (red_med)
   );

   assign rsp_valid           = s3_valid_ff;
   assign rsp_data.blue_out   = blue_med;
   assign rsp_data.green_out  = green_med;
   assign rsp_data.red_out    = red_med;
   assign rsp_data.frame_done = s3_done_ff;

   // Position counters stay inside the latched frame, and the virtual
   // column wrap is only meaningful while a frame drains.
   `ASSERT_HOLDS(a_col_in_frame, col_ff <= last_col_ff, "column position beyond frame width")
   `ASSERT_HOLDS(a_row_in_frame, row_ff <= last_row_ff, "row position beyond frame height")
   `ASSERT_IMPLIES(a_wrap_in_drain, wrap_ff, drain_ff, "flush wrap set outside drain")

endmodule
